@@ design/otb_pkg.sv @@
// ----------------------------------------------------------------------------
// otb_pkg
// shared types and constants of the opcode target buffer
// ----------------------------------------------------------------------------
package otb_pkg;

   localparam int unsigned KEY_W    = 8;
   localparam int unsigned TARGET_W = 32;
   localparam int unsigned STEP_W   = 16;
   localparam int unsigned CSR_W    = 32;
   localparam int unsigned CONF_W   = 2;
   localparam int unsigned USAGE_W  = 4;

   localparam logic [CONF_W-1:0]  CONF_MAX   = 2'd3;
   localparam logic [CONF_W-1:0]  CONF_INIT  = 2'd3;
   localparam logic [USAGE_W-1:0] USAGE_MAX  = 4'd8;
   localparam logic [USAGE_W-1:0] USAGE_INIT = 4'd4;

   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_UPDATE  = 1'b1;

   localparam logic CSR_STEP   = 1'b0;
   localparam logic CSR_RSTART = 1'b1;

   typedef struct packed {
      logic                       op;
      logic [KEY_W-1:0]           opcode;
      logic signed [TARGET_W-1:0] taken_jump;
   } req_type;

   typedef struct packed {
      logic                       entry_found;
      logic signed [TARGET_W-1:0] predicted_target;
   } rsp_type;

endpackage

@@ design/opcode_target_buffer_lru.sv @@
// ----------------------------------------------------------------------------
// opcode_target_buffer_lru
// fully associative opcode-keyed jump target buffer with recency replacement
// ----------------------------------------------------------------------------
// channel | dir | handshake           | payload
// req     | in  | req_valid/req_stall | req_data  (op, opcode, taken_jump)
// rsp     | out | rsp_valid/rsp_stall | rsp_data  (entry_found, predicted_target)
// csr     | in  | csr_we              | csr_index, csr_wdata
//
// predict item and any update that does not evict: lookup, commit and output
// states after accept; update that evicts from a full table: the victim walk,
// visiting one insertion rank per cycle, lies between lookup and commit
// one item in flight; req_stall is high from accept until the result leaves
// reset is synchronous and clears control and the entry used bits only
// a stalled result holds in the output register
// ----------------------------------------------------------------------------
module opcode_target_buffer_lru import otb_pkg::*; #(
   parameter int unsigned ENTRIES      = 16,
   parameter int unsigned RECENCY_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam int unsigned RB = RECENCY_BITS;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOOK   = 3'd1;
   localparam logic [2:0] ST_WALK   = 3'd2;
   localparam logic [2:0] ST_COMMIT = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   logic [2:0]          state_ff, state_in;
   req_type             req_ff;
   rsp_type             rsp_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [CSR_W-1:0]    rstart_ff;
   logic [CW-1:0]       count_ff;
   logic [IW-1:0]       walk_ff;      // insertion rank being visited
   logic [IW-1:0]       vict_ff;      // current victim slot
   logic                vset_ff;
   logic [IW-1:0]       slot_ff;      // slot to touch on commit
   logic                touch_ff;     // commit writes the buffer
   logic                alloc_ff;
   logic                found_ff;
   logic [TARGET_W-1:0] pred_ff;

   // cell row
   logic [ENTRIES-1:0]  hit, valid, used, sel, alloc, rdec;
   logic [TARGET_W-1:0] target [ENTRIES];
   logic [IW-1:0]       rank   [ENTRIES];
   logic [RB-1:0]       rec    [ENTRIES];
   logic [IW-1:0]       alloc_rank;
   logic [RB-1:0]       rec_start;
   logic                do_update;

   assign rec_start = RB'(rstart_ff);
   assign do_update = state_ff == ST_COMMIT && touch_ff;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      otb_cell #(.RB(RB), .IW(IW)) u_cell (
         .clock, .reset,
         .key(req_ff.opcode), .hit(hit[g]), .valid(valid[g]),
         .target(target[g]), .used(used[g]), .rank(rank[g]),
         .recency(rec[g]),
         .do_update, .sel(sel[g]), .alloc(alloc[g]),
         .alloc_rank, .rank_dec(rdec[g]),
         .jump(req_ff.taken_jump), .rec_start
      );
      assign sel[g]   = do_update && slot_ff == IW'(g);
      assign alloc[g] = sel[g] && alloc_ff;
      // on eviction younger entries move up one rank
      assign rdec[g]  = do_update && alloc_ff && count_ff == CW'(ENTRIES)
                        && used[g] && rank[g] > rank[slot_ff];
   end

   assign alloc_rank = (count_ff == CW'(ENTRIES)) ? IW'(ENTRIES - 1) : IW'(count_ff);

   // lookup: matching slot and lowest free slot
   logic          any_hit, any_free;
   logic [IW-1:0] hit_idx, free_idx;
   always_comb begin
      any_hit = 1'b0; hit_idx = '0; any_free = 1'b0; free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit[i]) begin any_hit = 1'b1; hit_idx = IW'(i); end
         if (!used[i]) begin any_free = 1'b1; free_idx = IW'(i); end
      end
   end

   // walk: slot holding the visited rank
   logic [IW-1:0] rk_idx;
   always_comb begin
      rk_idx = '0;
      for (int i = 0; i < ENTRIES; i++)
         if (used[i] && rank[i] == walk_ff) rk_idx = IW'(i);
   end

   logic miss_alloc;
   assign miss_alloc = req_ff.op == OP_UPDATE && !any_hit
                       && req_ff.taken_jump != TARGET_W'(step_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_LOOK;
         ST_LOOK:   state_in = (miss_alloc && !any_free) ? ST_WALK : ST_COMMIT;
         ST_WALK:   if (walk_ff == IW'(ENTRIES - 1)) state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_OUT;
         ST_OUT:    if (!rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= STEP_W'(2);
         rstart_ff <= CSR_W'(1024);
         count_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_STEP:   step_ff   <= csr_wdata[STEP_W-1:0];
               CSR_RSTART: rstart_ff <= csr_wdata;
               default:    ;
            endcase
         end
         if (do_update && alloc_ff && count_ff != CW'(ENTRIES))
            count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: if (req_valid) req_ff <= req_data;
         ST_LOOK: begin
            found_ff <= any_hit;
            pred_ff  <= (req_ff.op == OP_PREDICT && any_hit && valid[hit_idx])
                        ? target[hit_idx] : '0;
            touch_ff <= req_ff.op == OP_UPDATE && (any_hit || miss_alloc);
            alloc_ff <= miss_alloc;
            slot_ff  <= any_hit ? hit_idx : free_idx;
            walk_ff  <= '0;
            vset_ff  <= 1'b0;
         end
         ST_WALK: begin
            // oldest first, then strictly smaller recency among valid entries
            if (!vset_ff || (valid[rk_idx] && rec[rk_idx] < rec[vict_ff])) begin
               vict_ff <= rk_idx;
               slot_ff <= rk_idx;
            end
            vset_ff <= 1'b1;
            walk_ff <= walk_ff + 1'b1;
         end
         ST_COMMIT: begin
            rsp_ff.entry_found      <= found_ff;
            rsp_ff.predicted_target <= pred_ff;
         end
         default: ;
      endcase
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_OUT;
   assign rsp_data  = rsp_ff;

   // a result only follows a commit
   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_COMMIT)
      else $error("result without commit");

   // fill count never exceeds the entry count
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("fill count overflow");

   // a touched allocation marks its slot used
   a_alloc_used: assert property (@(posedge clock) disable iff (reset)
      (do_update && alloc_ff) |=> used[$past(slot_ff)])
      else $error("allocated slot not used");

endmodule

@@ design/otb_cell.sv @@
// ----------------------------------------------------------------------------
// otb_cell
// one buffer entry: key match, training, recency and insertion rank, which
// the victim walk of the buffer reads; the walk is no per-cell search chain
// ----------------------------------------------------------------------------
module otb_cell import otb_pkg::*; #(
   parameter int unsigned RB = 32,
   parameter int unsigned IW = 4
) (
   input  logic                clock,
   input  logic                reset,
   // lookup, evaluated in the lookup cycle
   input  logic [KEY_W-1:0]    key,
   output logic                hit,
   output logic                valid,
   output logic [TARGET_W-1:0] target,
   output logic                used,
   output logic [IW-1:0]       rank,
   output logic [RB-1:0]       recency,
   // commit strobes
   input  logic                do_update,   // decrement recency of the other used entries
   input  logic                sel,         // this entry is touched
   input  logic                alloc,       // this entry is (re)allocated
   input  logic [IW-1:0]       alloc_rank,
   input  logic                rank_dec,    // shift up one rank
   input  logic [TARGET_W-1:0] jump,
   input  logic [RB-1:0]       rec_start
);

   logic                used_ff, valid_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [TARGET_W-1:0] tgt_ff;
   logic [CONF_W-1:0]   conf_ff;
   logic [USAGE_W-1:0]  use_ff;
   logic [RB-1:0]       rec_ff;
   logic [IW-1:0]       rank_ff;

   assign hit     = used_ff && key_ff == key;
   assign valid   = valid_ff;
   assign target  = tgt_ff;
   assign used    = used_ff;
   assign rank    = rank_ff;
   assign recency = rec_ff;

   // training values start from fresh entry when allocating
   logic                v0;
   logic [TARGET_W-1:0] t0;
   logic [CONF_W-1:0]   c0;
   logic [USAGE_W-1:0]  u0;
   logic [RB-1:0]       r0;
   logic                valid_in;
   logic [TARGET_W-1:0] tgt_in;
   logic [CONF_W-1:0]   conf_in;
   logic [USAGE_W-1:0]  use_in;

   always_comb begin
      v0 = alloc ? 1'b1 : valid_ff;
      t0 = alloc ? '0 : tgt_ff;
      c0 = alloc ? CONF_INIT : conf_ff;
      u0 = alloc ? USAGE_INIT : use_ff;
      r0 = alloc ? rec_start : rec_ff;
      valid_in = v0;
      tgt_in   = t0;
      conf_in  = c0;
      use_in   = u0;
      if (v0) begin
         if (t0 == '0) begin
            tgt_in = jump;
         end else if (t0 == jump) begin
            if (c0 < CONF_MAX) conf_in = c0 + 1'b1;
            if (u0 < USAGE_MAX) use_in = u0 + 1'b1;
         end else begin
            if (c0 > 2'd1) begin
               conf_in = c0 - 1'b1;
            end else begin
               conf_in = CONF_INIT;
               tgt_in  = jump;
            end
            if (u0 > '0) use_in = u0 - 1'b1;
            else valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (alloc) begin
         used_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         valid_ff <= valid_in;
         tgt_ff   <= tgt_in;
         conf_ff  <= conf_in;
         use_ff   <= use_in;
      end
      if (alloc) begin
         key_ff  <= key;
         rank_ff <= alloc_rank;
      end else if (rank_dec) begin
         rank_ff <= rank_ff - 1'b1;
      end
      if (do_update && (used_ff || alloc)) begin
         // the touched entry keeps its count, or takes rec_start when allocated
         rec_ff <= sel ? r0 : rec_ff - 1'b1;
      end
   end

endmodule
